FILE: rtl/xpr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xpr_pkg
// Shared types and constants for the XOR parity chunk group repair core.
// ----------------------------------------------------------------------------
package xpr_pkg;

	localparam int unsigned MAX_CHUNK_BYTES  = 1024;
	localparam int unsigned MAX_GROUP_CHUNKS = 16;

	localparam int unsigned PAY_W   = 40;
	localparam int unsigned DCH_W   = 31;
	localparam int unsigned CB_W    = 11;
	localparam int unsigned GC_W    = 5;
	localparam int unsigned GRP_W   = 30;
	localparam int unsigned BP_W    = 12;
	localparam int unsigned DP_W    = 16;
	localparam int unsigned CFG_I_W = 2;

	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;

	typedef logic [1:0] action_t;
	localparam action_t ACT_BYTE = 2'd0;
	localparam action_t ACT_PULL = 2'd1;
	localparam action_t ACT_END  = 2'd2;
	localparam action_t ACT_NONE = 2'd3;

	typedef logic [2:0] status_t;
	localparam status_t ST_BYTE     = 3'd0;
	localparam status_t ST_CLEAN    = 3'd1;
	localparam status_t ST_REPAIRED = 3'd2;
	localparam status_t ST_UNRECOV  = 3'd3;
	localparam status_t ST_TRUNC    = 3'd4;
	localparam status_t ST_COMPLETE = 3'd5;
	localparam status_t ST_SHORT    = 3'd6;
	localparam status_t ST_REJECT   = 3'd7;

	typedef logic [CFG_I_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_PAYLOAD = 2'd0;
	localparam cfg_idx_t REG_DCHUNKS = 2'd1;
	localparam cfg_idx_t REG_CBYTES  = 2'd2;
	localparam cfg_idx_t REG_GCHUNKS = 2'd3;

	typedef enum logic [1:0] {
		PH_RECV,
		PH_DRAIN,
		PH_DONE,
		PH_FAIL
	} phase_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ACC,
		S_BYTE,
		S_DIV,
		S_RD,
		S_PULL
	} state_t;

endpackage
`default_nettype wire

FILE: rtl/xpr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xpr_if
// Channel interfaces: input beats, result beats and register writes.
// ----------------------------------------------------------------------------
interface xpr_in_if;
	logic              valid;
	logic              ready;
	xpr_pkg::action_t  action;
	logic [7:0]        byte_in;
	modport source (output valid, action, byte_in, input ready);
	modport sink (input valid, action, byte_in, output ready);
endinterface

interface xpr_out_if;
	logic                      valid;
	logic                      ready;
	xpr_pkg::status_t          status;
	logic [7:0]                data_byte;
	logic                      last_of_payload;
	logic [xpr_pkg::GRP_W-1:0] group_number;
	logic [3:0]                chunk_in_group;
	modport source (output valid, status, data_byte, last_of_payload, group_number,
		chunk_in_group, input ready);
	modport sink (input valid, status, data_byte, last_of_payload, group_number,
		chunk_in_group, output ready);
endinterface

interface xpr_cfg_if;
	logic                      valid;
	logic                      ready;
	xpr_pkg::cfg_idx_t         index;
	logic [xpr_pkg::PAY_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/xor_parity_chunk_group_repair_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xor_parity_chunk_group_repair_core
// Checks framed chunks by FNV-1a, stores a parity group and repairs one bad
// data chunk from the XOR of the group.
// ----------------------------------------------------------------------------
// One item at a time. A check byte is absorbed when accepted; a chunk byte
// passes accept with hash update and accumulator read, then accumulator and
// store write, then chunk bookkeeping; a pull starts the 16-step serial
// divider that splits the drain pointer into chunk and offset, then takes
// its result, does the memory reads and forms the byte. Other actions put
// their result in the output register when accepted. A result sits in an
// output register; the next item is taken once that register is empty. Both
// memories start unwritten; no clearing pass runs after reset.
module xor_parity_chunk_group_repair_core (
	input  wire logic clk,
	input  wire logic arst_n,
	xpr_in_if.sink    in_ch,
	xpr_out_if.source out_ch,
	xpr_cfg_if.sink   cfg
);
	import xpr_pkg::*;

	localparam int unsigned OFF_W  = MAX_CHUNK_BYTES > 1 ? $clog2(MAX_CHUNK_BYTES) : 1;
	localparam int unsigned DEPTH  = MAX_CHUNK_BYTES * MAX_GROUP_CHUNKS;
	localparam int unsigned ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;

	logic [7:0] store_mem [DEPTH];
	logic [7:0] acc_mem [MAX_CHUNK_BYTES];

	logic [PAY_W-1:0] payload_q;
	logic [DCH_W-1:0] dchunks_q;
	logic [CB_W-1:0]  cbytes_q;
	logic [GC_W-1:0]  gchunks_q;

	state_t           state_q;
	phase_t           phase_q;
	logic [31:0]      hash_q;
	logic [31:0]      check_q;
	logic [BP_W-1:0]  bp_q;
	logic [GC_W-1:0]  slot_q;
	logic [DCH_W-1:0] cc_q;
	logic [GRP_W-1:0] grp_q;
	logic [1:0]       bad_q;
	logic [GC_W-1:0]  bad_slot_q;
	logic [PAY_W-1:0] dlv_q;
	logic [DP_W-1:0]  dp_q;
	logic [CB_W-1:0]  off_q;
	logic [7:0]       byte_q;
	logic [DP_W-1:0]  dch_q;
	logic [CB_W-1:0]  doff_q;
	logic             dvalid_q;
	logic [7:0]       st_rd_q;
	logic [7:0]       acc_rd_q;

	logic             out_v_q;
	status_t          o_status_q;
	logic [7:0]       o_data_q;
	logic             o_last_q;
	logic [GRP_W-1:0] o_grp_q;
	logic [3:0]       o_chunk_q;

	logic [CB_W-1:0]  cb_eff;
	logic [GC_W-1:0]  gc_eff;
	logic [DCH_W-1:0] dc_eff;
	logic [DCH_W-1:0] rem_chunks;
	logic [GC_W-1:0]  g;
	logic [DCH_W-1:0] cc_fin;
	logic             fin_done;
	logic [DP_W-1:0]  len;
	logic             in_acc;
	logic [CB_W-1:0]  off_in;
	logic [31:0]      hx;
	logic [31:0]      hmul;
	logic             data_slot;
	logic             good;
	logic [7:0]       acc_new;
	logic [31:0]      st_waddr;
	logic [31:0]      st_raddr;
	logic             div_done;
	logic [DP_W-1:0]  div_quot;
	logic [CB_W-1:0]  div_rem;
	logic [PAY_W-1:0] dlv_n;
	logic [DP_W-1:0]  dp_n;
	logic [7:0]       pull_v;

	always_comb begin
		if (cbytes_q == '0) begin
			cb_eff = CB_W'(1);
		end else if (32'(cbytes_q) > MAX_CHUNK_BYTES) begin
			cb_eff = CB_W'(MAX_CHUNK_BYTES);
		end else begin
			cb_eff = cbytes_q;
		end
		if (gchunks_q == '0) begin
			gc_eff = GC_W'(1);
		end else if (32'(gchunks_q) > MAX_GROUP_CHUNKS) begin
			gc_eff = GC_W'(MAX_GROUP_CHUNKS);
		end else begin
			gc_eff = gchunks_q;
		end
		dc_eff     = dchunks_q == '0 ? DCH_W'(1) : dchunks_q;
		rem_chunks = dc_eff > cc_q ? dc_eff - cc_q : '0;
		g          = rem_chunks < DCH_W'(gc_eff) ? rem_chunks[GC_W-1:0] : gc_eff;
		if (g == '0) begin
			g = GC_W'(1);
		end
	end

	assign cc_fin    = cc_q + DCH_W'(g);
	assign fin_done  = cc_fin >= dc_eff;
	assign len       = DP_W'(g) * DP_W'(cb_eff);
	assign in_acc    = in_ch.valid && in_ch.ready;
	assign off_in    = CB_W'(bp_q - BP_W'(4));
	assign hx        = hash_q ^ {24'd0, in_ch.byte_in};
	assign hmul      = hx * FNV_PRIME;
	assign data_slot = slot_q < g;
	assign good      = hash_q == check_q;
	assign acc_new   = slot_q == '0 ? byte_q : acc_rd_q ^ byte_q;
	assign st_waddr  = 32'(slot_q) * MAX_CHUNK_BYTES + 32'(off_q);
	assign st_raddr  = 32'(div_quot) * MAX_CHUNK_BYTES + 32'(div_rem);
	assign dlv_n     = dlv_q + PAY_W'(1);
	assign dp_n      = dp_q + DP_W'(1);
	assign pull_v    = !dvalid_q ? 8'd0 :
		((bad_q == 2'd1 && dch_q == DP_W'(bad_slot_q)) ? st_rd_q ^ acc_rd_q : st_rd_q);

	xpr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_acc && in_ch.action == ACT_PULL && phase_q == PH_DRAIN),
		.dividend (dp_q),
		.divisor  (cb_eff),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	assign cfg.ready   = 1'b1;
	assign in_ch.ready = state_q == S_IDLE && !out_v_q;

	assign out_ch.valid           = out_v_q;
	assign out_ch.status          = o_status_q;
	assign out_ch.data_byte       = o_data_q;
	assign out_ch.last_of_payload = o_last_q;
	assign out_ch.group_number    = o_grp_q;
	assign out_ch.chunk_in_group  = o_chunk_q;

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_acc) begin
			acc_rd_q <= acc_mem[off_in[OFF_W-1:0]];
		end
		if (state_q == S_RD) begin
			acc_rd_q <= acc_mem[doff_q[OFF_W-1:0]];
			st_rd_q  <= store_mem[st_raddr[ADDR_W-1:0]];
		end
		if (state_q == S_ACC) begin
			acc_mem[off_q[OFF_W-1:0]] <= acc_new;
			if (data_slot) begin
				store_mem[st_waddr[ADDR_W-1:0]] <= byte_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_q  <= '0;
			dchunks_q  <= DCH_W'(1);
			cbytes_q   <= CB_W'(1024);
			gchunks_q  <= GC_W'(10);
			state_q    <= S_IDLE;
			phase_q    <= PH_RECV;
			hash_q     <= FNV_BASIS;
			check_q    <= '0;
			bp_q       <= '0;
			slot_q     <= '0;
			cc_q       <= '0;
			grp_q      <= '0;
			bad_q      <= '0;
			bad_slot_q <= '0;
			dlv_q      <= '0;
			dp_q       <= '0;
			out_v_q    <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_PAYLOAD: payload_q <= cfg.data;
					REG_DCHUNKS: dchunks_q <= cfg.data[DCH_W-1:0];
					REG_CBYTES:  cbytes_q  <= cfg.data[CB_W-1:0];
					REG_GCHUNKS: gchunks_q <= cfg.data[GC_W-1:0];
					default: ;
				endcase
			end
			if (out_v_q && out_ch.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && in_ch.action != ACT_NONE) begin
						o_data_q  <= '0;
						o_last_q  <= 1'b0;
						o_grp_q   <= grp_q;
						o_chunk_q <= '0;
						if (phase_q == PH_FAIL) begin
							out_v_q    <= 1'b1;
							o_status_q <= bad_q == 2'd2 ? ST_UNRECOV : ST_TRUNC;
						end else if (in_ch.action == ACT_BYTE) begin
							if (phase_q != PH_RECV) begin
								out_v_q    <= 1'b1;
								o_status_q <= ST_REJECT;
							end else if (bp_q < BP_W'(4)) begin
								if (bp_q == '0) begin
									check_q <= {24'd0, in_ch.byte_in};
								end else begin
									check_q <= check_q
										| ({24'd0, in_ch.byte_in} << {bp_q[1:0], 3'd0});
								end
								bp_q <= bp_q + 1'b1;
							end else begin
								hash_q  <= hmul;
								off_q   <= off_in;
								byte_q  <= in_ch.byte_in;
								state_q <= 32'(off_in) < MAX_CHUNK_BYTES ? S_ACC : S_BYTE;
							end
						end else if (in_ch.action == ACT_PULL) begin
							if (phase_q != PH_DRAIN) begin
								out_v_q    <= 1'b1;
								o_status_q <= ST_REJECT;
							end else begin
								state_q <= S_DIV;
							end
						end else begin
							out_v_q <= 1'b1;
							unique case (phase_q)
								PH_RECV: begin
									bad_q      <= '0;
									phase_q    <= PH_FAIL;
									o_status_q <= ST_TRUNC;
								end
								PH_DRAIN: o_status_q <= ST_REJECT;
								default:  o_status_q <= dlv_q >= payload_q ? ST_COMPLETE : ST_SHORT;
							endcase
						end
					end
				end
				S_ACC: state_q <= S_BYTE;
				S_BYTE: begin
					state_q <= S_IDLE;
					if (32'(off_q) + 32'd1 < 32'(cb_eff)) begin
						bp_q <= bp_q + 1'b1;
					end else begin
						hash_q <= FNV_BASIS;
						bp_q   <= '0;
						if (data_slot) begin
							if (!good) begin
								if (bad_q != 2'd2) begin
									bad_q <= bad_q + 1'b1;
								end
								bad_slot_q <= slot_q;
							end
							slot_q <= slot_q + 1'b1;
						end else begin
							out_v_q   <= 1'b1;
							o_data_q  <= '0;
							o_last_q  <= 1'b0;
							o_grp_q   <= grp_q;
							if (bad_q == '0 || (bad_q == 2'd1 && good)) begin
								o_status_q <= bad_q == '0 ? ST_CLEAN : ST_REPAIRED;
								o_chunk_q  <= bad_q == '0 ? 4'd0 : bad_slot_q[3:0];
								dp_q       <= '0;
								if (dlv_q >= payload_q) begin
									cc_q       <= cc_fin;
									grp_q      <= grp_q + 1'b1;
									bad_q      <= '0;
									bad_slot_q <= '0;
									slot_q     <= '0;
									phase_q    <= fin_done ? PH_DONE : PH_RECV;
								end else begin
									phase_q <= PH_DRAIN;
								end
							end else begin
								bad_q      <= 2'd2;
								phase_q    <= PH_FAIL;
								o_status_q <= ST_UNRECOV;
								o_chunk_q  <= '0;
							end
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						dch_q    <= div_quot;
						doff_q   <= div_rem;
						dvalid_q <= 32'(div_quot) < MAX_GROUP_CHUNKS
							&& 32'(div_rem) < MAX_CHUNK_BYTES;
						state_q  <= S_RD;
					end
				end
				S_RD: state_q <= S_PULL;
				S_PULL: begin
					state_q    <= S_IDLE;
					out_v_q    <= 1'b1;
					o_status_q <= ST_BYTE;
					o_data_q   <= pull_v;
					o_last_q   <= dlv_n == payload_q;
					o_grp_q    <= grp_q;
					o_chunk_q  <= '0;
					dlv_q      <= dlv_n;
					if (dp_n >= len || dlv_n >= payload_q) begin
						cc_q       <= cc_fin;
						grp_q      <= grp_q + 1'b1;
						bad_q      <= '0;
						bad_slot_q <= '0;
						slot_q     <= '0;
						bp_q       <= '0;
						dp_q       <= '0;
						phase_q    <= fin_done ? PH_DONE : PH_RECV;
					end else begin
						dp_q <= dp_n;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: rtl/xpr_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xpr_div
// Radix-2 restoring divider: drain pointer by chunk length, one bit a cycle.
// ----------------------------------------------------------------------------
module xpr_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [xpr_pkg::DP_W-1:0]  dividend,
	input  wire logic [xpr_pkg::CB_W-1:0]  divisor,
	output logic                           done,
	output logic [xpr_pkg::DP_W-1:0]       quot,
	output logic [xpr_pkg::CB_W-1:0]       rem
);
	import xpr_pkg::*;

	localparam int unsigned CNT_W = $clog2(DP_W + 1);

	logic [DP_W-1:0]  quo_q;
	logic [CB_W-1:0]  rem_q;
	logic [CB_W-1:0]  div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [CB_W:0]    trial;
	logic             fit;

	assign trial = {rem_q, quo_q[DP_W-1]};
	assign fit   = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DP_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fit ? CB_W'(trial - {1'b0, div_q}) : trial[CB_W-1:0];
			quo_q <= {quo_q[DP_W-2:0], fit};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;
endmodule
`default_nettype wire

FILE: verif/tb_xor_parity_chunk_group_repair_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_xor_parity_chunk_group_repair_core
// Self-checking bench: sends framed parity groups with random content and
// injected check errors, pulls the payload back and compares every result
// beat with an in-bench predictor of the repair core. Registers change
// only between runs of groups while the core is idle.
// ----------------------------------------------------------------------------
module tb_xor_parity_chunk_group_repair_core;
	import xpr_pkg::*;

	localparam int CB_MAX   = 1024;
	localparam int GC_MAX   = 16;
	localparam int WD_LIMIT = 4000;

	typedef struct packed {
		action_t    act;
		logic [7:0] data;
	} beat_t;

	typedef struct packed {
		status_t          st;
		logic [7:0]       db;
		logic             last;
		logic [GRP_W-1:0] grp;
		logic [3:0]       ch;
	} result_t;

	logic clk;
	logic arst_n;

	xpr_in_if  in_ch();
	xpr_out_if out_ch();
	xpr_cfg_if cfg();

	xor_parity_chunk_group_repair_core dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// predictor state
	logic [PAY_W-1:0] payload_len;
	logic [DCH_W-1:0] total_chunks;
	logic [CB_W-1:0]  chunk_len;
	logic [GC_W-1:0]  group_len;
	logic [7:0]       group_mem [GC_MAX*CB_MAX];
	logic [7:0]       parity_acc [CB_MAX];
	logic             chunk_ok [GC_MAX];
	logic [31:0]      fnv_hash, check_word;
	int unsigned      byte_pos, slot, drain_ptr;
	logic [DCH_W-1:0] consumed;
	logic [GRP_W-1:0] group_idx;
	int unsigned      bad_count, bad_idx;
	logic [PAY_W-1:0] delivered;
	phase_t           core_phase;

	result_t     expected_results[$];
	beat_t       pending_beats[$];
	int unsigned beats_queued, beats_taken;
	int unsigned fail_count;
	int          idle_mode;
	bit          in_took;
	int unsigned wd_count;

	// stimulus-side tracking
	longint unsigned plan_consumed, plan_delivered;

	function automatic int unsigned eff_chunk_len();
		if (chunk_len == 0) return 1;
		if (chunk_len > CB_MAX) return CB_MAX;
		return chunk_len;
	endfunction

	function automatic int unsigned group_size_at(longint unsigned cons);
		longint unsigned dc, rem, g;
		dc = (total_chunks == 0) ? 1 : total_chunks;
		rem = (dc > cons) ? dc - cons : 0;
		g = (group_len == 0) ? 1 : ((group_len > GC_MAX) ? GC_MAX : group_len);
		if (rem < g) g = rem;
		return (g == 0) ? 1 : int'(g);
	endfunction

	task automatic post_result(status_t st, logic [7:0] db, logic last, logic [3:0] ch);
		result_t r;
		r.st = st; r.db = db; r.last = last; r.grp = group_idx; r.ch = ch;
		expected_results = {expected_results, r};
	endtask

	task automatic close_group();
		longint unsigned dc;
		dc = (total_chunks == 0) ? 1 : total_chunks;
		consumed = DCH_W'(consumed + group_size_at(consumed));
		group_idx = GRP_W'(group_idx + 1);
		bad_count = 0; bad_idx = 0; slot = 0; byte_pos = 0; drain_ptr = 0;
		for (int i = 0; i < GC_MAX; i++) chunk_ok[i] = 1'b0;
		core_phase = (consumed >= dc) ? PH_DONE : PH_RECV;
	endtask

	task automatic predict_stream_byte(logic [7:0] b);
		int unsigned cb, g, off;
		bit good;
		cb = eff_chunk_len();
		g = group_size_at(consumed);
		if (byte_pos < 4) begin
			if (byte_pos == 0) check_word = {24'd0, b};
			else check_word |= {24'd0, b} << (8 * byte_pos);
			byte_pos++;
			return;
		end
		off = byte_pos - 4;
		fnv_hash = (fnv_hash ^ {24'd0, b}) * FNV_PRIME;
		if (off < CB_MAX) begin
			if (slot < g && slot < GC_MAX) group_mem[slot * CB_MAX + off] = b;
			if (slot == 0) parity_acc[off] = b;
			else parity_acc[off] ^= b;
		end
		if (off + 1 < cb) begin
			byte_pos++;
			return;
		end
		good = (fnv_hash == check_word);
		fnv_hash = FNV_BASIS;
		byte_pos = 0;
		if (slot < g && slot < GC_MAX) begin
			chunk_ok[slot] = good;
			if (!good) begin
				if (bad_count < 2) bad_count++;
				bad_idx = slot;
			end
			slot++;
			return;
		end
		if (bad_count == 0 || (bad_count == 1 && good)) begin
			post_result(bad_count == 0 ? ST_CLEAN : ST_REPAIRED, 8'd0, 1'b0,
				bad_count == 0 ? 4'd0 : 4'(bad_idx));
			if (delivered >= payload_len) close_group();
			else begin
				core_phase = PH_DRAIN;
				drain_ptr = 0;
			end
			return;
		end
		bad_count = 2;
		core_phase = PH_FAIL;
		post_result(ST_UNRECOV, 8'd0, 1'b0, 4'd0);
	endtask

	task automatic predict_pull();
		int unsigned cb, len, ch, off;
		logic [7:0] v;
		cb = eff_chunk_len();
		len = group_size_at(consumed) * cb;
		ch = drain_ptr / cb;
		off = drain_ptr % cb;
		v = 8'd0;
		if (ch < GC_MAX && off < CB_MAX) begin
			v = group_mem[ch * CB_MAX + off];
			if (bad_count == 1 && ch == bad_idx) v ^= parity_acc[off];
		end
		delivered = delivered + 1;
		drain_ptr++;
		post_result(ST_BYTE, v, delivered == payload_len, 4'd0);
		if (drain_ptr >= len || delivered >= payload_len) close_group();
	endtask

	task automatic predict_beat(action_t a, logic [7:0] b);
		if (a == ACT_NONE) return;
		if (core_phase == PH_FAIL) begin
			post_result(bad_count == 2 ? ST_UNRECOV : ST_TRUNC, 8'd0, 1'b0, 4'd0);
			return;
		end
		case (a)
			ACT_BYTE: begin
				if (core_phase != PH_RECV) post_result(ST_REJECT, 8'd0, 1'b0, 4'd0);
				else predict_stream_byte(b);
			end
			ACT_PULL: begin
				if (core_phase != PH_DRAIN) post_result(ST_REJECT, 8'd0, 1'b0, 4'd0);
				else predict_pull();
			end
			default: begin
				if (core_phase == PH_RECV) begin
					bad_count = 0;
					core_phase = PH_FAIL;
					post_result(ST_TRUNC, 8'd0, 1'b0, 4'd0);
				end else if (core_phase == PH_DRAIN) begin
					post_result(ST_REJECT, 8'd0, 1'b0, 4'd0);
				end else begin
					post_result(delivered >= payload_len ? ST_COMPLETE : ST_SHORT,
						8'd0, 1'b0, 4'd0);
				end
			end
		endcase
	endtask

	// accept side: prediction, register shadow, checking
	always @(posedge clk) begin
		result_t e;
		if (in_ch.valid && in_ch.ready) begin
			predict_beat(in_ch.action, in_ch.byte_in);
			beats_taken++;
			in_took = 1'b1;
		end
		if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_PAYLOAD: payload_len = cfg.data;
				REG_DCHUNKS: total_chunks = cfg.data[DCH_W-1:0];
				REG_CBYTES:  chunk_len = cfg.data[CB_W-1:0];
				default:     group_len = cfg.data[GC_W-1:0];
			endcase
		end
		if (out_ch.valid && out_ch.ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result beat, status %0d", out_ch.status);
				fail_count++;
			end else begin
				e = expected_results.pop_front();
				if (out_ch.status !== e.st) begin
					$error("status exp %0d got %0d", e.st, out_ch.status);
					fail_count++;
				end
				if (out_ch.data_byte !== e.db) begin
					$error("data_byte exp %0h got %0h", e.db, out_ch.data_byte);
					fail_count++;
				end
				if (out_ch.last_of_payload !== e.last) begin
					$error("last_of_payload exp %0d got %0d", e.last, out_ch.last_of_payload);
					fail_count++;
				end
				if (out_ch.group_number !== e.grp) begin
					$error("group_number exp %0d got %0d", e.grp, out_ch.group_number);
					fail_count++;
				end
				if (out_ch.chunk_in_group !== e.ch) begin
					$error("chunk_in_group exp %0d got %0d", e.ch, out_ch.chunk_in_group);
					fail_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg.valid && cfg.ready) || !arst_n) begin
			wd_count <= 0;
		end else if (wd_count + 1 >= WD_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			wd_count <= wd_count + 1;
		end
	end

	// input driver
	always @(negedge clk) begin
		beat_t bt;
		int idle_pct;
		idle_pct = (idle_mode == 1) ? 76 : ((idle_mode == 3) ? 22 : 0);
		if (arst_n && (!in_ch.valid || in_took)) begin
			in_took = 1'b0;
			if (pending_beats.size() > 0 && $urandom_range(99) >= idle_pct) begin
				bt = pending_beats.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.action <= bt.act;
				in_ch.byte_in <= bt.data;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// result receiver
	always @(negedge clk) begin
		int stall_pct;
		stall_pct = (idle_mode == 2) ? 76 : ((idle_mode == 3) ? 22 : 0);
		out_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic add_beat(action_t a, logic [7:0] b);
		beat_t bt;
		bt.act = a; bt.data = b;
		pending_beats = {pending_beats, bt};
		beats_queued++;
	endtask

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic receive_noise();
		if ($urandom_range(99) < 3)
			add_beat($urandom_range(1) ? ACT_PULL : ACT_NONE, rand_byte());
	endtask

	task automatic add_chunk(int unsigned n, bit bad);
		logic [7:0] data [$];
		logic [31:0] h;
		h = FNV_BASIS;
		for (int i = 0; i < n; i++) begin
			data = {data, rand_byte()};
			h = (h ^ {24'd0, data[i]}) * FNV_PRIME;
		end
		if (bad) h ^= 32'(1) << $urandom_range(31);
		for (int i = 0; i < 4; i++) begin
			receive_noise();
			add_beat(ACT_BYTE, h[8*i +: 8]);
		end
		foreach (data[i]) begin
			receive_noise();
			add_beat(ACT_BYTE, data[i]);
		end
	endtask

	// one group; up to nbad data chunks fail their check
	task automatic add_group(int unsigned nbad, bit bad_parity);
		int unsigned cb, g, pulls;
		bit bad_slot [GC_MAX];
		int unsigned k, tries;
		cb = eff_chunk_len();
		g = group_size_at(plan_consumed);
		for (int i = 0; i < GC_MAX; i++) bad_slot[i] = 1'b0;
		k = 0;
		tries = 0;
		while (k < nbad && k < g && tries < 100) begin
			int unsigned s;
			s = $urandom_range(g - 1);
			if (!bad_slot[s]) begin
				bad_slot[s] = 1'b1;
				k++;
			end
			tries++;
		end
		for (int s = 0; s < g; s++) add_chunk(cb, bad_slot[s]);
		add_chunk(cb, bad_parity);
		if (k >= 2 || (k == 1 && bad_parity)) return;
		pulls = 0;
		if (plan_delivered < payload_len) begin
			pulls = g * cb;
			if (payload_len - plan_delivered < pulls) pulls = 32'(payload_len - plan_delivered);
		end
		for (int i = 0; i < pulls; i++) begin
			if ($urandom_range(99) < 3) begin
				case ($urandom_range(2))
					0: add_beat(ACT_BYTE, rand_byte());
					1: add_beat(ACT_END, rand_byte());
					default: add_beat(ACT_NONE, rand_byte());
				endcase
			end
			add_beat(ACT_PULL, rand_byte());
		end
		plan_delivered += pulls;
		plan_consumed += g;
	endtask

	task automatic add_good_groups(int unsigned n);
		int unsigned nbad;
		for (int i = 0; i < n; i++) begin
			nbad = ($urandom_range(3) == 0) ? 1 : 0;
			add_group(nbad, nbad == 0 && $urandom_range(4) == 0);
		end
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [PAY_W-1:0] v);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= v;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic set_regs(logic [PAY_W-1:0] pay, logic [DCH_W-1:0] dc,
			logic [CB_W-1:0] cb, logic [GC_W-1:0] gc);
		write_reg(REG_PAYLOAD, pay);
		write_reg(REG_DCHUNKS, {9'd0, dc});
		write_reg(REG_CBYTES, {29'd0, cb});
		write_reg(REG_GCHUNKS, {35'd0, gc});
		plan_consumed = consumed;
		plan_delivered = delivered;
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (!(pending_beats.size() == 0 && beats_taken == beats_queued
			&& expected_results.size() == 0));
		repeat (40) @(negedge clk);
	endtask

	function automatic logic [PAY_W-1:0] pick_payload();
		case ($urandom_range(3))
			0: return '1;
			1: return 0;
			default: return delivered + $urandom_range(40);
		endcase
	endfunction

	initial begin
		int unsigned ph, ending;
		in_ch.valid = 1'b0; in_ch.action = ACT_NONE; in_ch.byte_in = 8'd0;
		out_ch.ready = 1'b0;
		cfg.valid = 1'b0; cfg.index = REG_PAYLOAD; cfg.data = '0;
		payload_len = 0; total_chunks = 1; chunk_len = 1024; group_len = 10;
		for (int i = 0; i < GC_MAX * CB_MAX; i++) group_mem[i] = 8'd0;
		for (int i = 0; i < CB_MAX; i++) parity_acc[i] = 8'd0;
		for (int i = 0; i < GC_MAX; i++) chunk_ok[i] = 1'b0;
		fnv_hash = FNV_BASIS; check_word = 0; byte_pos = 0; slot = 0; drain_ptr = 0;
		consumed = 0; group_idx = 0; bad_count = 0; bad_idx = 0; delivered = 0;
		core_phase = PH_RECV;
		beats_queued = 0; beats_taken = 0; fail_count = 0; idle_mode = 0;
		in_took = 1'b0; wd_count = 0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: smallest sizes, out-of-range sizes, max register values
		set_regs('1, 31'h7FFFFFFF, 11'd1, 5'd1);
		add_group(0, 0); add_group(0, 1); add_group(1, 0);
		wait_idle();
		idle_mode = 1;
		set_regs('1, 31'h7FFFFFFF, 11'd0, 5'd0);
		add_group(1, 0);
		wait_idle();
		idle_mode = 2;
		set_regs(delivered + 20, 31'h7FFFFFFF, 11'd2, 5'd31);
		add_group(1, 0);
		wait_idle();
		idle_mode = 3;
		set_regs(0, 31'h7FFFFFFF, 11'd3, 5'd16);
		add_group(0, 0);
		wait_idle();
		// longer chunk, payload cut mid-group
		idle_mode = 0;
		set_regs(delivered + 30, 31'h7FFFFFFF, 11'd60, 5'd1);
		add_group(1, 0);
		wait_idle();

		// random runs of groups
		ph = 0;
		while (beats_queued < 800) begin
			idle_mode = ph % 4;
			set_regs(pick_payload(), DCH_W'(31'h7FFFFFFF - $urandom_range(15)),
				($urandom_range(9) == 0) ? 11'd0 : 11'($urandom_range(1, 6)),
				($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(1, 16)));
			add_good_groups($urandom_range(1, 2));
			wait_idle();
			ph++;
		end

		// closing run: complete stream, unrecoverable group or truncation
		ending = $urandom_range(2);
		idle_mode = ph % 4;
		set_regs($urandom_range(1) ? delivered : '1, DCH_W'(consumed + $urandom_range(1, 3)),
			11'($urandom_range(1, 5)), 5'($urandom_range(2, 4)));
		case (ending)
			0: begin
				while (plan_consumed < total_chunks) add_good_groups(1);
				add_beat(ACT_BYTE, rand_byte());
				add_beat(ACT_PULL, rand_byte());
				add_beat(ACT_NONE, rand_byte());
				add_beat(ACT_END, rand_byte());
				add_beat(ACT_END, rand_byte());
			end
			1: begin
				if (group_size_at(plan_consumed) >= 2 && $urandom_range(1)) add_group(2, 0);
				else add_group(1, 1);
			end
			default: begin
				for (int i = 0; i < $urandom_range(6); i++) add_beat(ACT_BYTE, rand_byte());
				add_beat(ACT_END, rand_byte());
			end
		endcase
		for (int i = 0; i < 6; i++) add_beat(action_t'($urandom_range(3)), rand_byte());
		wait_idle();

		if (fail_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
`default_nettype wire

FILE: files.f
rtl/xpr_pkg.sv
rtl/xpr_if.sv
rtl/xpr_div.sv
rtl/xor_parity_chunk_group_repair_core.sv
verif/tb_xor_parity_chunk_group_repair_core.sv
